/* rtl/drgb_pkg.sv */
// Package: shared types and constants for the decimal RGB triplet parser.
`timescale 1ns / 1ps

package drgb_pkg;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_FIRST = 2'd1,
        PH_MORE  = 2'd2
    } t_phase;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HIGH  = 8'h80;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] ALPHA      = 8'hFF;
    localparam logic [11:0] CHAN_MAX  = 12'd255;
    localparam logic [1:0] LAST_SEP_IDX = 2'd2;

    typedef struct packed {
        logic [31:0] color_word;
        logic        status;
        logic        byte_left_over;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  chan_idx;
        logic [7:0]  chan_value;
        logic [15:0] packed_chans;
    } t_state;

    typedef struct packed {
        t_state  next_state;
        logic    emit;
        t_result result;
    } t_step;

endpackage

/* rtl/drgb_if.sv */
// Interfaces: input byte channel and result channel with valid/ready.
`timescale 1ns / 1ps

interface drgb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       prior_error;

    modport source (output valid, output text_byte, output prior_error, input ready);
    modport sink   (input valid, input text_byte, input prior_error, output ready);
endinterface

interface drgb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] color_word;
    logic        status;
    logic        byte_left_over;

    modport source (output valid, output color_word, output status,
                    output byte_left_over, input ready);
    modport sink   (input valid, input color_word, input status,
                    input byte_left_over, output ready);
endinterface

/* rtl/drgb_step.sv */
// Step logic: next parser state and optional result for one byte.
`timescale 1ns / 1ps

module drgb_step (
    input  drgb_pkg::t_state i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_perr,
    output drgb_pkg::t_step  o_step
);

    logic        w_digit;
    logic [3:0]  w_dval;
    logic [11:0] w_acc;
    logic        w_skip_phase;

    assign w_digit = (i_byte >= drgb_pkg::CHAR_ZERO) && (i_byte <= drgb_pkg::CHAR_NINE);
    assign w_dval  = 4'(i_byte - drgb_pkg::CHAR_ZERO);
    // value*10 + digit; value never exceeds 255 so 12 bits hold it
    assign w_acc   = ({4'd0, i_state.chan_value} << 3) + ({4'd0, i_state.chan_value} << 1)
                   + {8'd0, w_dval};
    assign w_skip_phase = (i_state.phase != drgb_pkg::PH_FIRST)
                       && (i_state.phase != drgb_pkg::PH_MORE);

    always_comb begin
        o_step.next_state = i_state;
        o_step.emit       = 1'b0;
        o_step.result     = '{color_word: 32'd0, status: 1'b1, byte_left_over: 1'b1};

        if (i_perr) begin
            o_step.emit = 1'b1;
        end else if (w_skip_phase && (i_byte == drgb_pkg::CHAR_NUL)) begin
            o_step.emit = 1'b1;
        end else if (w_skip_phase && ((i_byte <= drgb_pkg::CHAR_SPACE)
                                   || (i_byte >= drgb_pkg::CHAR_HIGH))) begin
            o_step.next_state.phase = drgb_pkg::PH_SKIP;
        end else if (w_skip_phase || (i_state.phase == drgb_pkg::PH_FIRST)) begin
            // first digit of a channel
            if (!w_digit) begin
                o_step.emit = 1'b1;
            end else begin
                o_step.next_state.chan_value = {4'd0, w_dval};
                o_step.next_state.phase      = drgb_pkg::PH_MORE;
            end
        end else if (w_digit) begin
            if (w_acc > drgb_pkg::CHAN_MAX) begin
                o_step.emit                  = 1'b1;
                o_step.result.byte_left_over = 1'b0;
            end else begin
                o_step.next_state.chan_value = w_acc[7:0];
            end
        end else if (i_state.chan_idx < drgb_pkg::LAST_SEP_IDX) begin
            if (i_byte != drgb_pkg::CHAR_COMMA) begin
                o_step.emit = 1'b1;
            end else begin
                o_step.next_state.packed_chans = {i_state.packed_chans[7:0],
                                                  i_state.chan_value};
                o_step.next_state.chan_idx     = i_state.chan_idx + 2'd1;
                o_step.next_state.chan_value   = 8'd0;
                o_step.next_state.phase        = drgb_pkg::PH_FIRST;
            end
        end else begin
            o_step.emit   = 1'b1;
            o_step.result = '{color_word: {i_state.packed_chans, i_state.chan_value,
                                           drgb_pkg::ALPHA},
                              status: 1'b0, byte_left_over: 1'b1};
        end

        if (o_step.emit) begin
            o_step.next_state = '{phase: drgb_pkg::PH_SKIP, chan_idx: 2'd0,
                                  chan_value: 8'd0, packed_chans: 16'd0};
        end
    end

endmodule

/* rtl/decimal_rgb_triplet_parser_core.sv */
// Top level: decimal "R,G,B" text color parser, one byte per transaction.
// Path: input register, combinational step logic, output register for any result.
// Throughput: one byte per cycle while the result sink keeps up; a result held by a
// stalled sink stops the step logic, and the input stalls once its register is full.
// Reset: synchronous, active low; clears the pipeline valids and parser state.
// Parser state updates when the input register drains into the step logic.
`timescale 1ns / 1ps

module decimal_rgb_triplet_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drgb_in_if.sink     i_text,
    drgb_out_if.source  o_color
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_perr;

    // parser state
    drgb_pkg::t_state r_state;

    // output register
    logic              r_out_valid;
    drgb_pkg::t_result r_out;

    drgb_pkg::t_step w_step;
    logic            w_advance;

    // The held byte moves through the step logic when the output slot is
    // free or being emptied this cycle; while a result sits stalled, every
    // held byte waits, even one that would yield no result.
    assign w_advance    = r_in_valid && (!r_out_valid || o_color.ready);
    assign i_text.ready = !r_in_valid || w_advance;

    drgb_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_perr  (r_in_perr),
        .o_step  (w_step)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.ready && i_text.valid) begin
            r_in_byte <= i_text.text_byte;
            r_in_perr <= i_text.prior_error;
        end
    end

    // parser state, cleared on each emitted result inside the step logic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: drgb_pkg::PH_SKIP, chan_idx: 2'd0,
                         chan_value: 8'd0, packed_chans: 16'd0};
        end else if (w_advance) begin
            r_state <= w_step.next_state;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_step.emit;
        end else if (o_color.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_step.emit) begin
            r_out <= w_step.result;
        end
    end

    assign o_color.valid          = r_out_valid;
    assign o_color.color_word     = r_out.color_word;
    assign o_color.status         = r_out.status;
    assign o_color.byte_left_over = r_out.byte_left_over;

endmodule

/* rtl/drgb_checker.sv */
// Checker: port-level assertions for the parser core, bound to the top level.
`timescale 1ns / 1ps

module drgb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_color_word,
    input logic        i_status,
    input logic        i_left_over
);

    // an error result always carries a zero color
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status) |-> (i_color_word == 32'd0))
        else $error("error result with nonzero color");

    // a good color always has full alpha and leaves its ending byte
    a_ok_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_status) |-> ((i_color_word[7:0] == 8'hFF) && i_left_over))
        else $error("good color without alpha or ending byte flag");

    // a consumed ending byte only comes from a range error
    a_consumed_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_left_over) |-> i_status)
        else $error("consumed ending byte on a good color");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_color_word) && $stable(i_status)
             && $stable(i_left_over)))
        else $error("stalled result changed");

endmodule

bind decimal_rgb_triplet_parser_core drgb_checker u_drgb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_color.valid),
    .i_out_ready  (o_color.ready),
    .i_color_word (o_color.color_word),
    .i_status     (o_color.status),
    .i_left_over  (o_color.byte_left_over)
);
